>>> hw/rtl/qibm_pkg.sv
// shared types and constants for the quad inverse bilinear map
package qibm_pkg;

   localparam int CoordW = 16;
   localparam int PixW   = 12;
   localparam int OutW   = 16;
   localparam int RegCnt = 8;
   localparam int CsrIdxW = 3;

   localparam logic [1:0] STAT_INSIDE  = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_DEGEN   = 2'd2;

   localparam logic [CsrIdxW-1:0] REG_UL_X = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_UL_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_LL_X = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_LL_Y = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_LR_X = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_LR_Y = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_UR_X = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_UR_Y = 3'd7;

   typedef struct packed {
      logic signed [PixW-1:0] pixel_x;
      logic signed [PixW-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [1:0]      map_status;
      logic [OutW-1:0] tex_u;
      logic [OutW-1:0] tex_v;
   } rsp_type;

endpackage

>>> hw/rtl/qibm_sqrt.sv
// pipelined integer square root, one result bit per stage
module qibm_sqrt import qibm_pkg::*; #(
   parameter int InW = 70,
   parameter int TagW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [InW-1:0]    in_rad,
   input  logic [TagW-1:0]   in_tag,
   output logic              out_valid,
   output logic [InW/2-1:0]  out_root,
   output logic [TagW-1:0]   out_tag
);
   localparam int RootW = InW / 2;

   logic              vld_ff  [RootW+1];
   logic [InW-1:0]    rem_ff  [RootW+1];
   logic [RootW-1:0]  root_ff [RootW+1];
   logic [TagW-1:0]   tag_ff  [RootW+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      rem_ff[0]  = in_rad;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
   end

   for (genvar s = 0; s < RootW; s++) begin : g_stage
      localparam int Bit = RootW - 1 - s;
      logic [InW+1:0]   trial_in;
      logic [RootW-1:0] cand_in;
      always_comb begin
         cand_in  = root_ff[s] | (RootW'(1) << Bit);
         // cand^2 - root^2 = (2*root + 2^bit) << bit
         trial_in = (({2'b0, InW'(root_ff[s])} << 1) + ((InW+2)'(1) << Bit)) << Bit;
      end
      logic              v_ff;
      logic [InW-1:0]    r_ff;
      logic [RootW-1:0]  q_ff;
      logic [TagW-1:0]   t_ff;
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else v_ff <= vld_ff[s];
         t_ff <= tag_ff[s];
         if (trial_in <= {2'b0, rem_ff[s]}) begin
            r_ff <= rem_ff[s] - trial_in[InW-1:0];
            q_ff <= cand_in;
         end else begin
            r_ff <= rem_ff[s];
            q_ff <= root_ff[s];
         end
      end
      always_comb begin
         vld_ff[s+1]  = v_ff;
         rem_ff[s+1]  = r_ff;
         root_ff[s+1] = q_ff;
         tag_ff[s+1]  = t_ff;
      end
   end

   assign out_valid = vld_ff[RootW];
   assign out_root  = root_ff[RootW];
   assign out_tag   = tag_ff[RootW];
endmodule

>>> hw/rtl/qibm_div.sv
// pipelined restoring divider: magnitude quotient with sticky remainder
module qibm_div import qibm_pkg::*; #(
   parameter int NumW = 64,
   parameter int DenW = 48,
   parameter int QW = 18,
   parameter int TagW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NumW-1:0]  in_num,
   input  logic [DenW-1:0]  in_den,
   input  logic [TagW-1:0]  in_tag,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo,
   output logic             out_rem_nz,
   output logic [TagW-1:0]  out_tag
);
   // computes floor(num / den) restricted to QW bits; caller scales num, and a
   // quotient needing more bits saturates to all ones with the sticky flag set
   localparam int RW = DenW + 1;

   logic            vld_ff [QW+1];
   logic [RW-1:0]   rem_ff [QW+1];
   logic [NumW-1:0] num_ff [QW+1];
   logic [DenW-1:0] den_ff [QW+1];
   logic [QW-1:0]   quo_ff [QW+1];
   logic            ovf_ff [QW+1];
   logic [TagW-1:0] tag_ff [QW+1];

   // the high part of num above QW bits is handled as one first step
   logic [NumW+RW-1:0] hi_in;
   logic               ovf_in;
   logic [RW-1:0]      r0_in;
   always_comb begin
      hi_in  = {{RW{1'b0}}, in_num} >> QW;
      // quotient bits above QW exist when high part >= den
      ovf_in = hi_in >= {{(NumW){1'b0}}, 1'b0, in_den};
      r0_in  = hi_in[RW-1:0];
      vld_ff[0] = in_valid;
      rem_ff[0] = ovf_in ? '0 : r0_in;
      num_ff[0] = in_num;
      den_ff[0] = in_den;
      quo_ff[0] = '0;
      ovf_ff[0] = ovf_in;
      tag_ff[0] = in_tag;
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int Bit = QW - 1 - s;
      logic [RW-1:0] sh_in;
      always_comb sh_in = {rem_ff[s][RW-2:0], num_ff[s][Bit]};
      logic            v_ff, o_ff;
      logic [RW-1:0]   r_ff;
      logic [NumW-1:0] n_ff;
      logic [DenW-1:0] d_ff;
      logic [QW-1:0]   q_ff;
      logic [TagW-1:0] t_ff;
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else v_ff <= vld_ff[s];
         n_ff <= num_ff[s];
         d_ff <= den_ff[s];
         t_ff <= tag_ff[s];
         o_ff <= ovf_ff[s];
         if (sh_in >= {1'b0, den_ff[s]}) begin
            r_ff <= sh_in - {1'b0, den_ff[s]};
            q_ff <= quo_ff[s] | (QW'(1) << Bit);
         end else begin
            r_ff <= sh_in;
            q_ff <= quo_ff[s];
         end
      end
      always_comb begin
         vld_ff[s+1] = v_ff;
         rem_ff[s+1] = r_ff;
         num_ff[s+1] = n_ff;
         den_ff[s+1] = d_ff;
         quo_ff[s+1] = q_ff;
         ovf_ff[s+1] = o_ff;
         tag_ff[s+1] = t_ff;
      end
   end

   assign out_valid  = vld_ff[QW];
   assign out_quo    = ovf_ff[QW] ? '1 : quo_ff[QW];
   assign out_rem_nz = ovf_ff[QW] | (rem_ff[QW] != '0);
   assign out_tag    = tag_ff[QW];
endmodule

>>> hw/rtl/quad_inverse_bilinear_map_top.sv
// quad inverse bilinear map, throughput one pixel per clock; 88 register stages:
// eleven single stages, the root pipeline (41 stages, one per root bit) and two
// dividers (UV_BITS+2 stages each)
// reset clears all corners to zero and drops every beat in flight
// the receiver cannot stall, so a result shows one cycle on rsp_valid
module quad_inverse_bilinear_map_top import qibm_pkg::*; #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int UV_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CoordW-1:0]    csr_wdata
);
   localparam int F   = COORD_FRAC_BITS;
   localparam int U   = UV_BITS;
   // value widths: coords 18b (pixel scaled), edges up to 19b, products 39b
   localparam int QCW = PixW + F + 2 > CoordW + 2 ? PixW + F + 2 : CoordW + 2;
   localparam int EW  = CoordW + 3;
   localparam int PW  = QCW + EW + 2;          // A,B,C
   localparam int DW  = 2 * PW + 3;            // discriminant
   localparam int SW  = DW / 2 + 1;
   localparam int RW  = 2 * SW;
   localparam int VW  = U + 3;                 // signed v/u, |x| <= 2*2^U
   localparam int NW  = PW + 2;                // sqrt - B magnitude
   localparam int DNW = PW + 2;                // 2A magnitude
   localparam int QW  = U + 2;
   localparam int XW  = EW + U + 3;            // den / num widths
   localparam int XNW = QCW + U + EW + 3;
   localparam int LoW = PW / 2;                // magnitude halves for the squares
   localparam int HiW = PW - LoW;
   localparam logic [VW-1:0] One = VW'(1) << U;
   localparam logic [QW-1:0] Sat = QW'(2) << U;

   // configuration
   logic signed [CoordW-1:0] cfg_ff [RegCnt];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCnt; i++) cfg_ff[i] <= '0;
      end else if (csr_write) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // edge vectors, static between writes
   logic signed [EW-1:0] b1x, b1y, b2x, b2y, b3x, b3y;
   always_comb begin
      b1x = EW'(cfg_ff[REG_LR_X]) - EW'(cfg_ff[REG_LL_X]);
      b1y = EW'(cfg_ff[REG_LR_Y]) - EW'(cfg_ff[REG_LL_Y]);
      b2x = EW'(cfg_ff[REG_UL_X]) - EW'(cfg_ff[REG_LL_X]);
      b2y = EW'(cfg_ff[REG_UL_Y]) - EW'(cfg_ff[REG_LL_Y]);
      b3x = EW'(cfg_ff[REG_LL_X]) - EW'(cfg_ff[REG_LR_X])
          - EW'(cfg_ff[REG_UL_X]) + EW'(cfg_ff[REG_UR_X]);
      b3y = EW'(cfg_ff[REG_LL_Y]) - EW'(cfg_ff[REG_LR_Y])
          - EW'(cfg_ff[REG_UL_Y]) + EW'(cfg_ff[REG_UR_Y]);
   end

   assign busy = 1'b0;
   logic acc;
   assign acc = start;

   // stage 1: q
   logic              s1_v_ff;
   logic signed [QCW-1:0] qx_ff, qy_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= acc;
      qx_ff <= (QCW'(req_data.pixel_x) <<< F) - QCW'(cfg_ff[REG_LL_X]);
      qy_ff <= (QCW'(req_data.pixel_y) <<< F) - QCW'(cfg_ff[REG_LL_Y]);
   end

   // stage 2: partial products
   logic s2_v_ff;
   logic signed [PW-1:0] p_b3qy_ff, p_b3qx_ff, p_b1qy_ff, p_b1qx_ff, a_ff, k_ff;
   logic signed [QCW-1:0] qx2_ff, qy2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      p_b3qy_ff <= PW'(b3x) * PW'(qy_ff);
      p_b3qx_ff <= PW'(b3y) * PW'(qx_ff);
      p_b1qy_ff <= PW'(b1x) * PW'(qy_ff);
      p_b1qx_ff <= PW'(b1y) * PW'(qx_ff);
      a_ff <= PW'(b2x) * PW'(b3y) - PW'(b2y) * PW'(b3x);
      k_ff <= PW'(b1x) * PW'(b2y) - PW'(b1y) * PW'(b2x);
      qx2_ff <= qx_ff;
      qy2_ff <= qy_ff;
   end

   // stage 3: A, B, C
   logic s3_v_ff;
   logic signed [PW-1:0] a3_ff, b3_ff, c3_ff;
   logic signed [QCW-1:0] qx3_ff, qy3_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      a3_ff <= a_ff;
      b3_ff <= p_b3qy_ff - p_b3qx_ff - k_ff;
      c3_ff <= p_b1qy_ff - p_b1qx_ff;
      qx3_ff <= qx2_ff;
      qy3_ff <= qy2_ff;
   end

   // stage 4a: magnitudes split in halves, partial products of the squares
   logic s4a_v_ff, acneg4a_ff;
   logic signed [PW-1:0] a4a_ff, b4a_ff, c4a_ff;
   logic signed [QCW-1:0] qx4a_ff, qy4a_ff;
   logic [2*HiW-1:0] bhh_ff, achh_ff;
   logic [HiW+LoW-1:0] bhl_ff, achl_ff, aclh_ff;
   logic [2*LoW-1:0] bll_ff, acll_ff;
   logic [PW-1:0] am_in, bm_in, cm_in;
   always_comb begin
      am_in = a3_ff[PW-1] ? -a3_ff : a3_ff;
      bm_in = b3_ff[PW-1] ? -b3_ff : b3_ff;
      cm_in = c3_ff[PW-1] ? -c3_ff : c3_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) s4a_v_ff <= 1'b0;
      else s4a_v_ff <= s3_v_ff;
      a4a_ff <= a3_ff; b4a_ff <= b3_ff; c4a_ff <= c3_ff;
      qx4a_ff <= qx3_ff; qy4a_ff <= qy3_ff;
      acneg4a_ff <= a3_ff[PW-1] != c3_ff[PW-1];
      bhh_ff  <= bm_in[PW-1:LoW] * bm_in[PW-1:LoW];
      bhl_ff  <= bm_in[PW-1:LoW] * bm_in[LoW-1:0];
      bll_ff  <= bm_in[LoW-1:0] * bm_in[LoW-1:0];
      achh_ff <= am_in[PW-1:LoW] * cm_in[PW-1:LoW];
      achl_ff <= am_in[PW-1:LoW] * cm_in[LoW-1:0];
      aclh_ff <= am_in[LoW-1:0] * cm_in[PW-1:LoW];
      acll_ff <= am_in[LoW-1:0] * cm_in[LoW-1:0];
   end

   // stage 4b: squares
   logic s4_v_ff;
   logic signed [PW-1:0] a4_ff, b4_ff, c4_ff;
   logic signed [QCW-1:0] qx4_ff, qy4_ff;
   logic [RW-1:0] bb_ff, ac4_ff;
   logic [RW-1:0] bbsum_in, acmag_in;
   always_comb begin
      bbsum_in = (RW'(bhh_ff) << (2 * LoW)) + (RW'(bhl_ff) << (LoW + 1)) + RW'(bll_ff);
      acmag_in = (RW'(achh_ff) << (2 * LoW)) + ((RW'(achl_ff) + RW'(aclh_ff)) << LoW)
               + RW'(acll_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else s4_v_ff <= s4a_v_ff;
      a4_ff <= a4a_ff; b4_ff <= b4a_ff; c4_ff <= c4a_ff;
      qx4_ff <= qx4a_ff; qy4_ff <= qy4a_ff;
      bb_ff  <= bbsum_in;
      ac4_ff <= (acneg4a_ff ? -acmag_in : acmag_in) << 2;
   end

   // stage 5: discriminant and case
   logic s5_v_ff, lin5_ff, deg5_ff, out5_ff;
   logic signed [PW-1:0] a5_ff, b5_ff, c5_ff;
   logic signed [QCW-1:0] qx5_ff, qy5_ff;
   logic [RW-1:0] disc5_ff;
   logic signed [RW-1:0] disc_in;
   always_comb disc_in = $signed(bb_ff) - $signed(ac4_ff);
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else s5_v_ff <= s4_v_ff;
      a5_ff <= a4_ff; b5_ff <= b4_ff; c5_ff <= c4_ff;
      qx5_ff <= qx4_ff; qy5_ff <= qy4_ff;
      lin5_ff  <= a4_ff == '0;
      deg5_ff  <= (a4_ff == '0) && (b4_ff == '0);
      out5_ff  <= (a4_ff != '0) && (disc_in <= 0);
      disc5_ff <= disc_in[RW-1] ? '0 : disc_in;
   end

   // square root pipeline; side data rides in the tag
   localparam int T1W = 3 + 3 * PW + 2 * QCW;
   logic [T1W-1:0] t1_in, t1_out;
   logic s6_v;
   logic [SW-1:0] root6;
   assign t1_in = {lin5_ff, deg5_ff, out5_ff, a5_ff, b5_ff, c5_ff, qx5_ff, qy5_ff};
   qibm_sqrt #(.InW(RW), .TagW(T1W)) u_sqrt (
      .clock, .reset, .in_valid(s5_v_ff), .in_rad(disc5_ff), .in_tag(t1_in),
      .out_valid(s6_v), .out_root(root6), .out_tag(t1_out));

   logic lin6, deg6, out6;
   logic signed [PW-1:0] a6, b6, c6;
   logic signed [QCW-1:0] qx6, qy6;
   assign {lin6, deg6, out6, a6, b6, c6, qx6, qy6} = t1_out;

   // stage 7: v numerator / denominator
   logic s7_v_ff, deg7_ff, out7_ff, neg7_ff;
   logic [NW-1:0] vn7_ff;
   logic [DNW-1:0] vd7_ff;
   logic signed [QCW-1:0] qx7_ff, qy7_ff;
   logic signed [NW-1:0] n_in, d_in;
   always_comb begin
      if (lin6) begin
         n_in = -NW'(c6);
         d_in = NW'(b6);
      end else begin
         n_in = NW'({1'b0, root6}) - NW'(b6);
         d_in = NW'(a6) <<< 1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else s7_v_ff <= s6_v;
      deg7_ff <= deg6; out7_ff <= out6;
      neg7_ff <= (n_in < 0) != (d_in < 0);
      vn7_ff  <= n_in[NW-1] ? -n_in : n_in;
      vd7_ff  <= (d_in == '0) ? DNW'(1) : (d_in[NW-1] ? -d_in : d_in);
      qx7_ff  <= qx6; qy7_ff <= qy6;
   end

   localparam int T2W = 3 + 2 * QCW;
   logic [T2W-1:0] t2_out;
   logic s8_v, vrnz8;
   logic [QW-1:0] vq8;
   qibm_div #(.NumW(NW + U), .DenW(DNW), .QW(QW), .TagW(T2W)) u_vdiv (
      .clock, .reset, .in_valid(s7_v_ff), .in_num({vn7_ff, U'(0)}), .in_den(vd7_ff),
      .in_tag({deg7_ff, out7_ff, neg7_ff, qx7_ff, qy7_ff}),
      .out_valid(s8_v), .out_quo(vq8), .out_rem_nz(vrnz8), .out_tag(t2_out));

   logic deg8, out8, neg8;
   logic signed [QCW-1:0] qx8, qy8;
   assign {deg8, out8, neg8, qx8, qy8} = t2_out;

   // stage 9: round v (ceiling), saturate
   logic s9_v_ff, deg9_ff, out9_ff;
   logic signed [VW-1:0] v9_ff;
   logic signed [QCW-1:0] qx9_ff, qy9_ff;
   logic [QW:0] vm_in;
   always_comb begin
      vm_in = {1'b0, vq8} + {{QW{1'b0}}, (!neg8 && vrnz8)};
      if (vm_in > {1'b0, Sat}) vm_in = {1'b0, Sat};
   end
   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else s9_v_ff <= s8_v;
      deg9_ff <= deg8; out9_ff <= out8;
      v9_ff <= neg8 ? -VW'(vm_in) : VW'(vm_in);
      qx9_ff <= qx8; qy9_ff <= qy8;
   end

   // stage 10: den components and numerators
   logic s10_v_ff, deg10_ff, out10_ff;
   logic signed [VW-1:0] v10_ff;
   logic signed [XW-1:0] dx10_ff, dy10_ff;
   logic signed [XNW-1:0] nx10_ff, ny10_ff;
   always_ff @(posedge clock) begin
      if (reset) s10_v_ff <= 1'b0;
      else s10_v_ff <= s9_v_ff;
      deg10_ff <= deg9_ff; out10_ff <= out9_ff; v10_ff <= v9_ff;
      dx10_ff <= (XW'(b1x) <<< U) + XW'(b3x) * XW'(v9_ff);
      dy10_ff <= (XW'(b1y) <<< U) + XW'(b3y) * XW'(v9_ff);
      nx10_ff <= (XNW'(qx9_ff) <<< U) - XNW'(b2x) * XNW'(v9_ff);
      ny10_ff <= (XNW'(qy9_ff) <<< U) - XNW'(b2y) * XNW'(v9_ff);
   end

   // stage 11: axis choice and signs
   logic s11_v_ff, deg11_ff, out11_ff, neg11_ff;
   logic signed [VW-1:0] v11_ff;
   logic [XNW-1:0] un11_ff;
   logic [XW-1:0] ud11_ff;
   logic [XW-1:0] adx, ady;
   logic signed [XNW-1:0] sn;
   logic signed [XW-1:0] sd;
   always_comb begin
      adx = dx10_ff[XW-1] ? -dx10_ff : dx10_ff;
      ady = dy10_ff[XW-1] ? -dy10_ff : dy10_ff;
      if (adx > ady) begin
         sn = nx10_ff; sd = dx10_ff;
      end else begin
         sn = ny10_ff; sd = dy10_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s11_v_ff <= 1'b0;
      else s11_v_ff <= s10_v_ff;
      deg11_ff <= deg10_ff || (!out10_ff && sd == '0);
      out11_ff <= out10_ff;
      v11_ff   <= v10_ff;
      neg11_ff <= (sn < 0) != (sd < 0);
      un11_ff  <= sn[XNW-1] ? -sn : sn;
      ud11_ff  <= (sd == '0) ? XW'(1) : (sd[XW-1] ? -sd : sd);
   end

   localparam int T3W = 3 + VW;
   logic [T3W-1:0] t3_out;
   logic s12_v, urnz12;
   logic [QW-1:0] uq12;
   qibm_div #(.NumW(XNW + U), .DenW(XW), .QW(QW), .TagW(T3W)) u_udiv (
      .clock, .reset, .in_valid(s11_v_ff), .in_num({un11_ff, U'(0)}), .in_den(ud11_ff),
      .in_tag({deg11_ff, out11_ff, neg11_ff, v11_ff}),
      .out_valid(s12_v), .out_quo(uq12), .out_rem_nz(urnz12), .out_tag(t3_out));

   logic deg12, out12, neg12;
   logic signed [VW-1:0] v12;
   assign {deg12, out12, neg12, v12} = t3_out;

   // stage 13: floor u, status and output
   logic [QW:0] um;
   logic signed [VW-1:0] u13, omv;
   logic ins;
   always_comb begin
      um = {1'b0, uq12} + {{QW{1'b0}}, (neg12 && urnz12)};
      if (um > {1'b0, Sat}) um = {1'b0, Sat};
      u13 = neg12 ? -VW'(um) : VW'(um);
      omv = $signed(One) - v12;
      ins = (u13 >= 0) && (u13 < $signed(One)) && (v12 > 0) && (v12 <= $signed(One));
   end

   function automatic logic [OutW-1:0] to_out(input logic [VW-1:0] x);
      logic [VW+OutW-1:0] w;
      w = {{OutW{1'b0}}, x};
      if (U >= OutW) w = w >> (U - OutW);
      else w = w << (OutW - U);
      return w[OutW-1:0];
   endfunction

   rsp_type rsp_in;
   always_comb begin
      rsp_in = '0;
      if (deg12) rsp_in.map_status = STAT_DEGEN;
      else if (out12 || !ins) rsp_in.map_status = STAT_OUTSIDE;
      else begin
         rsp_in.map_status = STAT_INSIDE;
         rsp_in.tex_u = to_out(u13);
         rsp_in.tex_v = to_out(omv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= s12_v;
      rsp_data <= rsp_in;
   end
endmodule

>>> tb/tb.sv
// testbench for quad_inverse_bilinear_map_top: directed corner sets, then random quads
module tb;
   import qibm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits  = 4;
   localparam int UvBits    = 16;
   localparam int DrainWait = 120;
   localparam int CycleCap  = 400000;
   localparam int SetCnt    = 6;
   localparam int RowCnt    = 25;

   typedef logic signed [127:0] wide_type;
   typedef logic [CoordW-1:0] corner_set_type [RegCnt];

   typedef struct {
      int      setup;
      int      px;
      int      py;
      bit      known;
      rsp_type want;
   } pixel_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [CoordW-1:0]  csr_wdata;

   logic signed [CoordW-1:0] corner [RegCnt];
   rsp_type pending_maps [$];
   int      mismatches = 0;
   int      cycles = 0;
   int      idle_pct = 20;

   // register order: ul_x ul_y ll_x ll_y lr_x lr_y ur_x ur_y
   corner_set_type corner_sets [SetCnt] = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd256},
      '{16'd64, 16'd512, 16'd0, 16'd0, 16'd512, 16'd0, 16'd400, 16'd480},
      // all corners on one line
      '{16'd100, 16'd0, 16'd0, 16'd0, 16'd300, 16'd0, 16'd400, 16'd0},
      '{16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff},
      // twisted bowtie, some pixels get no real root
      '{16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256, 16'd0}
   };

   localparam rsp_type Degen = '{map_status: STAT_DEGEN, tex_u: '0, tex_v: '0};
   localparam rsp_type Blank = '0;

   pixel_row_type pixel_rows [RowCnt] = '{
      '{0, 0, 0, 1, Degen}, '{0, -2048, -2048, 1, Degen},
      '{0, 2047, 2047, 1, Degen}, '{0, -2048, 2047, 1, Degen},
      '{1, 0, 0, 0, Blank}, '{1, 8, 8, 0, Blank}, '{1, 15, 0, 0, Blank},
      '{1, 16, 16, 0, Blank}, '{1, -1, 5, 0, Blank}, '{1, 2047, -2048, 0, Blank},
      '{1, 8, 15, 0, Blank},
      '{2, 10, 10, 0, Blank}, '{2, 30, 25, 0, Blank}, '{2, -2048, 0, 0, Blank},
      '{3, 5, 0, 1, Degen}, '{3, 100, 100, 1, Degen},
      '{4, 0, 0, 0, Blank}, '{4, 2047, 2047, 0, Blank},
      '{4, -2048, -2048, 0, Blank}, '{4, 2047, -2048, 0, Blank},
      '{4, -1000, 1500, 0, Blank},
      '{5, 8, 8, 0, Blank}, '{5, 4, 12, 0, Blank}, '{5, 12, 4, 0, Blank},
      '{5, 8, 2, 0, Blank}
   };

   quad_inverse_bilinear_map_top #(
      .COORD_FRAC_BITS(FracBits),
      .UV_BITS(UvBits)
   ) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic wide_type mag(wide_type x);
      return (x < 0) ? -x : x;
   endfunction

   // n * 2^UV / d, rounded up or down, clamped to magnitude 2
   function automatic wide_type scaled_quot(wide_type n, wide_type d, bit round_up);
      bit neg;
      wide_type an, ad, m, r, sat;
      neg = (n < 0) != (d < 0);
      an = mag(n);
      ad = mag(d);
      sat = wide_type'(2) <<< UvBits;
      if (an / ad >= 2) begin
         m = sat;
      end else begin
         m = (an <<< UvBits) / ad;
         r = (an <<< UvBits) % ad;
         if ((round_up != neg) && r != 0) m = m + 1;
         if (m > sat) m = sat;
      end
      return neg ? -m : m;
   endfunction

   function automatic wide_type root_floor(wide_type d);
      wide_type res, cand;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (wide_type'(1) <<< b);
         if (cand * cand <= d) res = cand;
      end
      return res;
   endfunction

   function automatic rsp_type map_pixel(req_type p);
      wide_type one, qx, qy, b1x, b1y, b2x, b2y, b3x, b3y;
      wide_type a, b, c, disc, v, u, dx, dy, num, den, tv;
      rsp_type o;
      one = wide_type'(1) <<< UvBits;
      o = '0;
      qx = wide_type'(p.pixel_x) * (2 ** FracBits) - wide_type'(corner[REG_LL_X]);
      qy = wide_type'(p.pixel_y) * (2 ** FracBits) - wide_type'(corner[REG_LL_Y]);
      b1x = wide_type'(corner[REG_LR_X]) - wide_type'(corner[REG_LL_X]);
      b1y = wide_type'(corner[REG_LR_Y]) - wide_type'(corner[REG_LL_Y]);
      b2x = wide_type'(corner[REG_UL_X]) - wide_type'(corner[REG_LL_X]);
      b2y = wide_type'(corner[REG_UL_Y]) - wide_type'(corner[REG_LL_Y]);
      b3x = wide_type'(corner[REG_LL_X]) - wide_type'(corner[REG_LR_X])
            - wide_type'(corner[REG_UL_X]) + wide_type'(corner[REG_UR_X]);
      b3y = wide_type'(corner[REG_LL_Y]) - wide_type'(corner[REG_LR_Y])
            - wide_type'(corner[REG_UL_Y]) + wide_type'(corner[REG_UR_Y]);
      a = b2x * b3y - b2y * b3x;
      b = (b3x * qy - b3y * qx) - (b1x * b2y - b1y * b2x);
      c = b1x * qy - b1y * qx;
      if (a == 0) begin
         if (b == 0) begin
            o.map_status = STAT_DEGEN;
            return o;
         end
         v = scaled_quot(-c, b, 1'b1);
      end else begin
         disc = b * b - 4 * a * c;
         if (disc <= 0) begin
            o.map_status = STAT_OUTSIDE;
            return o;
         end
         v = scaled_quot(root_floor(disc) - b, 2 * a, 1'b1);
      end
      dx = b1x * one + b3x * v;
      dy = b1y * one + b3y * v;
      if (mag(dx) > mag(dy)) begin
         num = qx * one - b2x * v;
         den = dx;
      end else begin
         num = qy * one - b2y * v;
         den = dy;
      end
      if (den == 0) begin
         o.map_status = STAT_DEGEN;
         return o;
      end
      u = scaled_quot(num, den, 1'b0);
      if (u >= 0 && u < one && v > 0 && v <= one) begin
         tv = one - v;
         o.map_status = STAT_INSIDE;
         o.tex_u = u[OutW-1:0];
         o.tex_v = tv[OutW-1:0];
      end else begin
         o.map_status = STAT_OUTSIDE;
      end
      return o;
   endfunction

   task automatic flag(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_maps.size() == 0) begin
            flag("result beat with nothing pending");
         end else begin
            want = pending_maps.pop_front();
            if (rsp_data.map_status !== want.map_status)
               flag($sformatf("map_status %0d, want %0d", rsp_data.map_status,
                    want.map_status));
            if (rsp_data.tex_u !== want.tex_u)
               flag($sformatf("tex_u %0h, want %0h", rsp_data.tex_u, want.tex_u));
            if (rsp_data.tex_v !== want.tex_v)
               flag($sformatf("tex_v %0h, want %0h", rsp_data.tex_v, want.tex_v));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold one pixel beat until accepted, then maybe idle
   task automatic send_pixel(int px, int py, bit known, rsp_type typed);
      req_type p;
      p.pixel_x = px[PixW-1:0];
      p.pixel_y = py[PixW-1:0];
      req_data <= p;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_maps.push_back(known ? typed : map_pixel(p));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic load_corners(corner_set_type vals);
      drain();
      for (int r = 0; r < RegCnt; r++) begin
         csr_write <= 1'b1;
         csr_index <= r[CsrIdxW-1:0];
         csr_wdata <= vals[r];
         @(posedge clock);
         corner[r] = vals[r];
      end
      csr_write <= 1'b0;
   endtask

   function automatic int clamp(int x, int lo, int hi);
      return (x < lo) ? lo : (x > hi) ? hi : x;
   endfunction

   initial begin
      corner_set_type vals;
      int cur_set, cx, cy, spread, kind, lo_x, hi_x, lo_y, hi_y, px, py;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      foreach (corner[r]) corner[r] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_set = -1;
      foreach (pixel_rows[i]) begin
         if (pixel_rows[i].setup != cur_set) begin
            cur_set = pixel_rows[i].setup;
            if (cur_set != 0) load_corners(corner_sets[cur_set]);
         end
         send_pixel(pixel_rows[i].px, pixel_rows[i].py, pixel_rows[i].known,
                    pixel_rows[i].want);
      end

      for (int ph = 0; ph < 8; ph++) begin
         kind = ph % 4;
         cx = int'($urandom_range(2000)) - 1000;
         cy = int'($urandom_range(2000)) - 1000;
         spread = $urandom_range(1024, 16);
         for (int r = 0; r < RegCnt; r++) begin
            if (kind == 1)
               vals[r] = CoordW'($urandom_range(65535));
            else
               vals[r] = CoordW'(clamp(((r % 2) ? cy : cx) * 16
                                       + int'($urandom_range(2 * spread)) - spread,
                                       -32768, 32767));
         end
         // parallelogram: linear root path
         if (kind == 2) begin
            vals[REG_UR_X] = CoordW'(clamp(int'($signed(vals[REG_UL_X]))
                                           + int'($signed(vals[REG_LR_X]))
                                           - int'($signed(vals[REG_LL_X])), -32768, 32767));
            vals[REG_UR_Y] = CoordW'(clamp(int'($signed(vals[REG_UL_Y]))
                                           + int'($signed(vals[REG_LR_Y]))
                                           - int'($signed(vals[REG_LL_Y])), -32768, 32767));
         end
         load_corners(vals);
         lo_x = 4095; hi_x = -4096; lo_y = 4095; hi_y = -4096;
         for (int r = 0; r < RegCnt; r += 2) begin
            lo_x = clamp(int'($signed(vals[r])) >>> 4, -4096, lo_x);
            hi_x = clamp(int'($signed(vals[r])) >>> 4, hi_x, 4095);
            lo_y = clamp(int'($signed(vals[r + 1])) >>> 4, -4096, lo_y);
            hi_y = clamp(int'($signed(vals[r + 1])) >>> 4, hi_y, 4095);
         end
         lo_x = clamp(lo_x - 2, -2048, 2047);
         hi_x = clamp(hi_x + 2, -2048, 2047);
         lo_y = clamp(lo_y - 2, -2048, 2047);
         hi_y = clamp(hi_y + 2, -2048, 2047);
         idle_pct = (ph == 3) ? 0 : 20;
         for (int n = 0; n < 85; n++) begin
            if ($urandom_range(99) < 85) begin
               px = lo_x + int'($urandom_range(hi_x - lo_x));
               py = lo_y + int'($urandom_range(hi_y - lo_y));
            end else begin
               px = $urandom_range(4095);
               py = $urandom_range(4095);
            end
            send_pixel(px, py, 1'b0, Blank);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/qibm_pkg.sv
hw/rtl/qibm_sqrt.sv
hw/rtl/qibm_div.sv
hw/rtl/quad_inverse_bilinear_map_top.sv
tb/tb.sv
